// ----- rtl/core/i2cbs_pkg.sv -----
// Shared types and constants for the I2C master bit sequencer.
`default_nettype none

package i2cbs_pkg;

    // Command codes carried on the cmd field. Code seven is unused.
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_SACK  = 3'd5,
        CMD_RACK  = 3'd6
    } t_cmd;

    localparam logic [4:0] START_LAST = 5'd3;
    localparam logic [4:0] STOP_LAST  = 5'd2;
    localparam logic [4:0] WRITE_LAST = 5'd23;
    localparam logic [4:0] READ_LAST  = 5'd24;
    localparam logic [4:0] SACK_LAST  = 5'd2;
    localparam logic [4:0] RACK_LAST  = 5'd3;

    // Phases within one bit slot of a byte transfer.
    localparam logic [1:0] PH_DATA = 2'd0;
    localparam logic [1:0] PH_HIGH = 2'd1;
    localparam logic [1:0] PH_LOW  = 2'd2;

    // Architectural state of the sequencer.
    typedef struct packed {
        logic       scl;
        logic       sda;
        t_cmd       cmd;
        logic [4:0] idx;
        logic [1:0] ph;
        logic [2:0] bit_no;
        logic [7:0] shift;
        logic       ack_seen;
        logic       busy;
        logic [7:0] hold;
    } t_state;

    // Per-beat status produced alongside the next state.
    typedef struct packed {
        logic done;
        logic rejected;
    } t_flags;

endpackage

`default_nettype wire

// ----- rtl/core/i2c_master_bit_sequencer_top.sv -----
// Top level of the I2C master bit sequencer: state and result registers.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+-------------------------------------------
//  in      | input     | i_valid / o_ready   | i_cmd, i_tx_byte, i_ack_level, i_sda_in
//  out     | output    | o_valid / i_ready   | o_scl_level, o_sda_level, o_busy_res,
//          |           |                     | o_done_res, o_rx_byte, o_rx_ack, o_rejected
//
// Every input beat produces exactly one output beat, registered on its accepting edge.
// The sequencer state and the result register are both loaded on the accepting edge,
// so a new beat can be taken every cycle; the single-entry result register sets the rate.
// The input side stalls only while a result is held and the output side is not ready.
// Reset is synchronous and active low: both lines go high, the sequencer goes idle.
`default_nettype none

module i2c_master_bit_sequencer_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_cmd,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_ack_level,
    input  wire logic       i_sda_in,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_scl_level,
    output logic            o_sda_level,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic [7:0]      o_rx_byte,
    output logic            o_rx_ack,
    output logic            o_rejected
);

    i2cbs_pkg::t_state r_state;
    i2cbs_pkg::t_state n_state;
    i2cbs_pkg::t_flags n_flags;
    i2cbs_pkg::t_flags r_flags;
    logic              r_out_valid;
    logic              in_beat;

    // The result register can take a new beat whenever it is empty or draining.
    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;

    i2cbs_step u_step (
        .i_state     (r_state),
        .i_cmd       (i2cbs_pkg::t_cmd'(i_cmd)),
        .i_tx_byte   (i_tx_byte),
        .i_ack_level (i_ack_level),
        .i_sda_in    (i_sda_in),
        .o_state     (n_state),
        .o_flags     (n_flags)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.scl      <= 1'b1;
            r_state.sda      <= 1'b1;
            r_state.cmd      <= i2cbs_pkg::CMD_TICK;
            r_state.idx      <= '0;
            r_state.ph       <= i2cbs_pkg::PH_DATA;
            r_state.bit_no   <= '0;
            r_state.shift    <= '0;
            r_state.ack_seen <= 1'b0;
            r_state.busy     <= 1'b0;
            r_state.hold     <= '0;
            r_flags          <= '0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state     <= n_state;
                r_flags     <= n_flags;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result is the state left by the last accepted beat plus its flags.
    assign o_valid     = r_out_valid;
    assign o_scl_level = r_state.scl;
    assign o_sda_level = r_state.sda;
    assign o_busy_res  = r_state.busy;
    assign o_done_res  = r_flags.done;
    assign o_rx_byte   = r_state.shift;
    assign o_rx_ack    = r_state.ack_seen;
    assign o_rejected  = r_flags.rejected;

`ifndef ASSERT_OFF
    // A finished command always leaves the sequencer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported while still busy");

    // A command is only refused while a sequence is running.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rejected) |-> o_busy_res)
        else $error("command rejected while idle");

    // One beat cannot both finish a command and refuse another.
    a_done_xor_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_done_res && o_rejected))
        else $error("done and rejected in the same beat");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/i2cbs_step.sv -----
// Next-state logic: applies one input beat to the sequencer state.
`default_nettype none

module i2cbs_step (
    input  var i2cbs_pkg::t_state i_state,
    input  var i2cbs_pkg::t_cmd   i_cmd,
    input  wire logic [7:0]       i_tx_byte,
    input  wire logic             i_ack_level,
    input  wire logic             i_sda_in,
    output i2cbs_pkg::t_state     o_state,
    output i2cbs_pkg::t_flags     o_flags
);

    logic [4:0] last;
    logic       step_bit;

    always_comb begin
        o_state  = i_state;
        o_flags  = '0;
        last     = '0;
        step_bit = 1'b0;
        if (i_cmd inside {[i2cbs_pkg::CMD_START:i2cbs_pkg::CMD_RACK]}) begin
            if (i_state.busy) begin
                o_flags.rejected = 1'b1;
            end else begin
                o_state.cmd    = i_cmd;
                o_state.idx    = '0;
                o_state.ph     = i2cbs_pkg::PH_DATA;
                o_state.bit_no = '0;
                o_state.busy   = 1'b1;
                if (i_cmd == i2cbs_pkg::CMD_WRITE) begin
                    o_state.hold = i_tx_byte;
                end else if (i_cmd == i2cbs_pkg::CMD_SACK) begin
                    o_state.hold = {7'd0, i_ack_level};
                end
                if (i_cmd == i2cbs_pkg::CMD_READ) begin
                    o_state.shift = '0;
                end
            end
        end else if (i_cmd == i2cbs_pkg::CMD_TICK && i_state.busy) begin
            case (i_state.cmd)
                i2cbs_pkg::CMD_START: begin
                    last = i2cbs_pkg::START_LAST;
                    case (i_state.idx[1:0])
                        2'd0:    o_state.sda = 1'b1;
                        2'd1:    o_state.scl = 1'b1;
                        2'd2:    o_state.sda = 1'b0;
                        default: o_state.scl = 1'b0;
                    endcase
                end
                i2cbs_pkg::CMD_STOP: begin
                    last = i2cbs_pkg::STOP_LAST;
                    case (i_state.idx[1:0])
                        2'd0:    o_state.sda = 1'b0;
                        2'd1:    o_state.scl = 1'b1;
                        default: o_state.sda = 1'b1;
                    endcase
                end
                i2cbs_pkg::CMD_WRITE: begin
                    last     = i2cbs_pkg::WRITE_LAST;
                    step_bit = 1'b1;
                    case (i_state.ph)
                        i2cbs_pkg::PH_DATA: o_state.sda = i_state.hold[3'd7 - i_state.bit_no];
                        i2cbs_pkg::PH_HIGH: o_state.scl = 1'b1;
                        default:            o_state.scl = 1'b0;
                    endcase
                end
                i2cbs_pkg::CMD_READ: begin
                    last = i2cbs_pkg::READ_LAST;
                    if (i_state.idx == 5'd0) begin
                        // Release the data line before the first clock pulse.
                        o_state.sda = 1'b1;
                    end else begin
                        step_bit = 1'b1;
                        case (i_state.ph)
                            i2cbs_pkg::PH_DATA: o_state.scl = 1'b1;
                            i2cbs_pkg::PH_HIGH: begin
                                if (i_sda_in) begin
                                    o_state.shift[3'd7 - i_state.bit_no] = 1'b1;
                                end
                            end
                            default: o_state.scl = 1'b0;
                        endcase
                    end
                end
                i2cbs_pkg::CMD_SACK: begin
                    last = i2cbs_pkg::SACK_LAST;
                    case (i_state.idx[1:0])
                        2'd0:    o_state.sda = i_state.hold[0];
                        2'd1:    o_state.scl = 1'b1;
                        default: o_state.scl = 1'b0;
                    endcase
                end
                i2cbs_pkg::CMD_RACK: begin
                    last = i2cbs_pkg::RACK_LAST;
                    case (i_state.idx[1:0])
                        2'd0:    o_state.sda = 1'b1;
                        2'd1:    o_state.scl = 1'b1;
                        2'd2:    o_state.ack_seen = i_sda_in;
                        default: o_state.scl = 1'b0;
                    endcase
                end
                default: last = '0;
            endcase

            if (step_bit) begin
                if (i_state.ph == i2cbs_pkg::PH_LOW) begin
                    o_state.ph     = i2cbs_pkg::PH_DATA;
                    o_state.bit_no = i_state.bit_no + 3'd1;
                end else begin
                    o_state.ph = i_state.ph + 2'd1;
                end
            end

            if (i_state.idx >= last) begin
                o_state.busy  = 1'b0;
                o_state.cmd   = i2cbs_pkg::CMD_TICK;
                o_state.idx   = '0;
                o_flags.done  = 1'b1;
            end else begin
                o_state.idx = i_state.idx + 5'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- bench/tb_i2c_master_bit_sequencer_top.sv -----
// Self-checking testbench for the I2C master bit sequencer, with its own line-level predictor.
module tb_i2c_master_bit_sequencer_top;

    // Code seven carries no command; the block must leave everything as it is.
    localparam logic [2:0] CMD_NONE = 3'd7;
    // Cycles without any accepted beat on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 1000;
    // Length of the forced receiver hold-off that backs the block up.
    localparam int HOLD_OFF_CYCLES = 80;
    // Counted items per random phase.
    localparam int PHASE_ITEMS = 80;

    // One input beat as the driver presents it.
    typedef struct {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       ack_level;
        logic       sda_in;
    } t_bus_request;

    // One result beat: the line levels and status after an input beat.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       rx_ack;
        logic       rejected;
    } t_line_status;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_cmd;
    logic [7:0] i_tx_byte;
    logic       i_ack_level;
    logic       i_sda_in;
    logic       o_valid;
    logic       i_ready;
    logic       o_scl_level;
    logic       o_sda_level;
    logic       o_busy_res;
    logic       o_done_res;
    logic [7:0] o_rx_byte;
    logic       o_rx_ack;
    logic       o_rejected;

    i2c_master_bit_sequencer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_tx_byte   (i_tx_byte),
        .i_ack_level (i_ack_level),
        .i_sda_in    (i_sda_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_scl_level (o_scl_level),
        .o_sda_level (o_sda_level),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_rx_byte   (o_rx_byte),
        .o_rx_ack    (o_rx_ack),
        .o_rejected  (o_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Beats waiting to be driven, and line states waiting to come out of the block.
    t_bus_request pending_requests[$];
    t_line_status expected_line_q[$];

    // Bookkeeping shared between the stimulus, driver and monitor processes.
    int  requests_queued = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  mismatch_count = 0;
    int  stall_cycles = 0;
    int  counted_items = 0;
    int  phase_no = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  in_taken = 1'b0;

    // Predictor state: the two bus lines and the command sequencer.
    logic            bus_scl;
    logic            bus_sda;
    i2cbs_pkg::t_cmd seq_cmd;
    logic [4:0]      seq_step;
    logic [7:0]      rd_shift;
    logic            rack_level;
    logic            seq_busy;
    logic [7:0]      tx_hold;

    // Advances the predicted bus by one accepted input beat and queues the line
    // status that the block must report for it. Commands only latch; ticks move pins.
    task automatic step_sequencer(input logic [2:0] code, input logic [7:0] tx,
                                  input logic ack_lvl, input logic sda_smp);
        t_line_status st;
        logic [4:0]   last_step;
        logic [4:0]   rel;
        logic [2:0]   slot;
        logic [1:0]   phase;
        st = '0;
        last_step = '0;
        if (code >= i2cbs_pkg::CMD_START && code <= i2cbs_pkg::CMD_RACK) begin
            if (seq_busy) begin
                // A command while a sequence runs is dropped and flagged.
                st.rejected = 1'b1;
            end else begin
                seq_cmd  = i2cbs_pkg::t_cmd'(code);
                seq_step = '0;
                seq_busy = 1'b1;
                if (code == i2cbs_pkg::CMD_WRITE) begin
                    tx_hold = tx;
                end else if (code == i2cbs_pkg::CMD_SACK) begin
                    tx_hold = {7'd0, ack_lvl};
                end
                if (code == i2cbs_pkg::CMD_READ) begin
                    rd_shift = '0;
                end
            end
        end else if (code == i2cbs_pkg::CMD_TICK && seq_busy) begin
            // Byte transfers run in three-action bit slots; a read has one
            // extra action up front that releases the data line.
            rel   = (seq_cmd == i2cbs_pkg::CMD_READ) ? seq_step - 5'd1 : seq_step;
            slot  = 3'(rel / 5'd3);
            phase = 2'(rel % 5'd3);
            case (seq_cmd)
                i2cbs_pkg::CMD_START: begin
                    last_step = i2cbs_pkg::START_LAST;
                    case (seq_step)
                        5'd0:    bus_sda = 1'b1;
                        5'd1:    bus_scl = 1'b1;
                        5'd2:    bus_sda = 1'b0;
                        default: bus_scl = 1'b0;
                    endcase
                end
                i2cbs_pkg::CMD_STOP: begin
                    last_step = i2cbs_pkg::STOP_LAST;
                    case (seq_step)
                        5'd0:    bus_sda = 1'b0;
                        5'd1:    bus_scl = 1'b1;
                        default: bus_sda = 1'b1;
                    endcase
                end
                i2cbs_pkg::CMD_WRITE: begin
                    last_step = i2cbs_pkg::WRITE_LAST;
                    if (phase == i2cbs_pkg::PH_DATA) begin
                        bus_sda = tx_hold[3'd7 - slot];
                    end else if (phase == i2cbs_pkg::PH_HIGH) begin
                        bus_scl = 1'b1;
                    end else begin
                        bus_scl = 1'b0;
                    end
                end
                i2cbs_pkg::CMD_READ: begin
                    last_step = i2cbs_pkg::READ_LAST;
                    if (seq_step == 5'd0) begin
                        bus_sda = 1'b1;
                    end else if (phase == i2cbs_pkg::PH_DATA) begin
                        bus_scl = 1'b1;
                    end else if (phase == i2cbs_pkg::PH_HIGH) begin
                        // Sample while the clock is still high; bits only get set.
                        if (sda_smp) begin
                            rd_shift[3'd7 - slot] = 1'b1;
                        end
                    end else begin
                        bus_scl = 1'b0;
                    end
                end
                i2cbs_pkg::CMD_SACK: begin
                    last_step = i2cbs_pkg::SACK_LAST;
                    case (seq_step)
                        5'd0:    bus_sda = tx_hold[0];
                        5'd1:    bus_scl = 1'b1;
                        default: bus_scl = 1'b0;
                    endcase
                end
                i2cbs_pkg::CMD_RACK: begin
                    last_step = i2cbs_pkg::RACK_LAST;
                    case (seq_step)
                        5'd0:    bus_sda = 1'b1;
                        5'd1:    bus_scl = 1'b1;
                        5'd2:    rack_level = sda_smp;
                        default: bus_scl = 1'b0;
                    endcase
                end
                default: last_step = '0;
            endcase
            if (seq_step >= last_step) begin
                st.done  = 1'b1;
                seq_busy = 1'b0;
                seq_cmd  = i2cbs_pkg::CMD_TICK;
                seq_step = '0;
            end else begin
                seq_step = seq_step + 5'd1;
            end
        end
        // Idle ticks and the empty code fall through with nothing changed.
        st.scl     = bus_scl;
        st.sda     = bus_sda;
        st.busy    = seq_busy;
        st.rx_byte = rd_shift;
        st.rx_ack  = rack_level;
        expected_line_q.push_back(st);
    endtask

    task automatic push_item(input logic [2:0] code, input logic [7:0] tx,
                             input logic ack_lvl, input logic sda_lvl);
        t_bus_request req;
        req.cmd       = code;
        req.tx_byte   = tx;
        req.ack_level = ack_lvl;
        req.sda_in    = sda_lvl;
        pending_requests.push_back(req);
        requests_queued++;
    endtask

    // Queues one command followed by exactly enough ticks to finish it. The data
    // line seen on each tick is high with the given likelihood. With noise on, stray
    // commands land mid-sequence, where the block has to reject or ignore them.
    task automatic push_sequence(input logic [2:0] code, input logic [7:0] tx,
                                 input logic ack_lvl, input int ones_pct, input bit noisy);
        int n_ticks;
        case (code)
            i2cbs_pkg::CMD_START: n_ticks = i2cbs_pkg::START_LAST + 1;
            i2cbs_pkg::CMD_STOP:  n_ticks = i2cbs_pkg::STOP_LAST + 1;
            i2cbs_pkg::CMD_WRITE: n_ticks = i2cbs_pkg::WRITE_LAST + 1;
            i2cbs_pkg::CMD_READ:  n_ticks = i2cbs_pkg::READ_LAST + 1;
            i2cbs_pkg::CMD_SACK:  n_ticks = i2cbs_pkg::SACK_LAST + 1;
            default:              n_ticks = i2cbs_pkg::RACK_LAST + 1;
        endcase
        push_item(code, tx, ack_lvl, 1'($urandom_range(1)));
        counted_items++;
        repeat (n_ticks) begin
            if (noisy && $urandom_range(15) == 0) begin
                push_item(3'($urandom_range(7, 1)), 8'($urandom), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            push_item(i2cbs_pkg::CMD_TICK, 8'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(99) < ones_pct));
            counted_items++;
        end
    endtask

    task automatic check_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("beat %0d: %s expected %h, got %h", beats_out, field, want, got);
            end
        end
    endtask

    // Monitor: samples both handshakes at the rising edge. A result beat is checked
    // against the oldest queued expectation; an accepted input beat is run through
    // the predictor. The watchdog counts edges on which neither channel moves.
    always @(posedge i_clk) begin
        t_line_status want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_line_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("beat %0d: result with nothing expected", beats_out);
                    end
                end else begin
                    want = expected_line_q.pop_front();
                    check_field("scl_level", 8'(want.scl), 8'(o_scl_level));
                    check_field("sda_level", 8'(want.sda), 8'(o_sda_level));
                    check_field("busy_res", 8'(want.busy), 8'(o_busy_res));
                    check_field("done_res", 8'(want.done), 8'(o_done_res));
                    check_field("rx_byte", want.rx_byte, o_rx_byte);
                    check_field("rx_ack", 8'(want.rx_ack), 8'(o_rx_ack));
                    check_field("rejected", 8'(want.rejected), 8'(o_rejected));
                end
                beats_out++;
            end
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                step_sequencer(i_cmd, i_tx_byte, i_ack_level, i_sda_in);
                beats_in++;
            end
            if (in_taken || (o_valid && i_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    // Driver: on the falling edge, once the current beat has been taken (or none is
    // up), either presents the next queued beat or leaves the input idle. A beat that
    // is up stays untouched until the block takes it.
    always @(negedge i_clk) begin
        t_bus_request req;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                req = pending_requests.pop_front();
                i_cmd       <= req.cmd;
                i_tx_byte   <= req.tx_byte;
                i_ack_level <= req.ack_level;
                i_sda_in    <= req.sda_in;
                i_valid     <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls per phase, plus one long hold-off at the start
    // of the last phase so the single result register fills and the input backs up.
    always @(negedge i_clk) begin
        int  hold_left;
        bit  hold_used;
        if (phase_no == 2 && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_cmd       = i2cbs_pkg::CMD_TICK;
        i_tx_byte   = '0;
        i_ack_level = 1'b0;
        i_sda_in    = 1'b0;

        // Predicted state after reset: both lines released, sequencer idle.
        bus_scl    = 1'b1;
        bus_sda    = 1'b1;
        seq_cmd    = i2cbs_pkg::CMD_TICK;
        seq_step   = '0;
        rd_shift   = '0;
        rack_level = 1'b0;
        seq_busy   = 1'b0;
        tx_hold    = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int p = 0; p < 3; p++) begin
            @(posedge i_clk);
            phase_no = p;
            // Sender idles 27 percent and receiver 62 percent first, then the
            // other way round, then both run flat out.
            tx_idle_pct = (p == 0) ? 27 : (p == 1) ? 62 : 0;
            rx_idle_pct = (p == 0) ? 62 : (p == 1) ? 27 : 0;
            if (p == 0) begin
                // Idle tick and empty code while idle: nothing may move.
                push_item(i2cbs_pkg::CMD_TICK, 8'hFF, 1'b1, 1'b1);
                push_item(CMD_NONE, 8'h00, 1'b0, 1'b0);
                // Start, with a command and the empty code arriving while it runs.
                push_item(i2cbs_pkg::CMD_START, 8'h00, 1'b0, 1'b0);
                push_item(i2cbs_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0);
                push_item(i2cbs_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b1);
                push_item(CMD_NONE, 8'hFF, 1'b1, 1'b1);
                repeat (3) push_item(i2cbs_pkg::CMD_TICK, 8'h00, 1'b0, 1'b0);
                // Byte transfers at the extremes of data, then both ack levels
                // each way, and a stop to close.
                push_sequence(i2cbs_pkg::CMD_WRITE, 8'hFF, 1'b0, 50, 1'b0);
                push_sequence(i2cbs_pkg::CMD_READ, 8'h00, 1'b0, 100, 1'b0);
                push_sequence(i2cbs_pkg::CMD_WRITE, 8'h00, 1'b1, 50, 1'b0);
                push_sequence(i2cbs_pkg::CMD_READ, 8'hFF, 1'b1, 0, 1'b0);
                push_sequence(i2cbs_pkg::CMD_SACK, 8'h00, 1'b1, 50, 1'b0);
                push_sequence(i2cbs_pkg::CMD_SACK, 8'hFF, 1'b0, 50, 1'b0);
                push_sequence(i2cbs_pkg::CMD_RACK, 8'h00, 1'b0, 100, 1'b0);
                push_sequence(i2cbs_pkg::CMD_RACK, 8'h00, 1'b0, 0, 1'b0);
                push_sequence(i2cbs_pkg::CMD_STOP, 8'h00, 1'b0, 50, 1'b0);
            end
            // Mostly complete command sequences with random content; now and then
            // a stray idle tick or empty code between them.
            counted_items = 0;
            while (counted_items < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    push_item($urandom_range(1) ? i2cbs_pkg::CMD_TICK : CMD_NONE,
                              8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
                end else begin
                    push_sequence(3'($urandom_range(6, 1)), 8'($urandom),
                                  1'($urandom_range(1)), 50, 1'b1);
                end
            end
            // Drain before the idling pattern changes.
            while (beats_in != requests_queued || beats_out != beats_in) begin
                @(posedge i_clk);
            end
        end

        // The result is registered; spare edges catch any stray result beat.
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && expected_line_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
